// File: sv/u8dec_pkg.sv
// Shared types, codes and bit masks of the UTF-8 sequence decoder.
`default_nettype none

package u8dec_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_INVALID   = 2'd1,
    ST_PREMATURE = 2'd2
  } status_t;

  // Byte marker bits, high to low.
  localparam logic [7:0] BIT_7 = 8'o200;
  localparam logic [7:0] BIT_6 = 8'o100;
  localparam logic [7:0] BIT_5 = 8'o040;
  localparam logic [7:0] BIT_4 = 8'o020;

  // Masks and tags of the lead and continuation byte forms.
  localparam logic [7:0] CONT_MASK  = BIT_7 | BIT_6;
  localparam logic [7:0] CONT_TAG   = BIT_7;
  localparam logic [7:0] LEAD2_MASK = BIT_7 | BIT_6 | BIT_5;
  localparam logic [7:0] LEAD2_TAG  = BIT_7 | BIT_6;
  localparam logic [7:0] LEAD3_MASK = BIT_7 | BIT_6 | BIT_5 | BIT_4;
  localparam logic [7:0] LEAD3_TAG  = BIT_7 | BIT_6 | BIT_5;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = BIT_7 | BIT_6 | BIT_5 | BIT_4;

  // Window size and sequence lengths.
  localparam logic [2:0] AVAIL_MAX = 3'd4;
  localparam logic [2:0] LEN_1     = 3'd1;
  localparam logic [2:0] LEN_2     = 3'd2;
  localparam logic [2:0] LEN_3     = 3'd3;
  localparam logic [2:0] LEN_4     = 3'd4;

  // Item after lead classification.
  typedef struct packed {
    logic        valid;
    logic        empty;
    logic        bad_lead;
    logic [2:0]  len;
    logic [2:0]  avail;
    logic [2:0]  cont_ok;
    logic [6:0]  lead;
    logic [17:0] tail;
  } s1_t;

  // Item after status resolution.
  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [2:0]  consumed;
    logic [2:0]  missing;
    logic [6:0]  lead;
    logic [17:0] tail;
  } s2_t;

endpackage

`default_nettype wire

// File: sv/u8dec_lead_stage.sv
// First pipeline stage: count clamp, lead byte class and continuation byte checks.
`default_nettype none

module u8dec_lead_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [7:0]      byte_first,
  input  wire logic [7:0]      byte_second,
  input  wire logic [7:0]      byte_third,
  input  wire logic [7:0]      byte_fourth,
  input  wire logic [2:0]      bytes_available,
  output u8dec_pkg::s1_t       s1
);

  u8dec_pkg::s1_t s1_next;

  // Classify the lead byte and tag each following byte; reset clears the valid bit.
  always_comb begin
    s1_next = '0;
    s1_next.valid = in_valid && !rst;
    s1_next.avail = (bytes_available > u8dec_pkg::AVAIL_MAX) ?
                    u8dec_pkg::AVAIL_MAX : bytes_available;
    s1_next.empty = (bytes_available == 3'd0);
    if ((byte_first & u8dec_pkg::BIT_7) == 8'd0) begin
      s1_next.len = u8dec_pkg::LEN_1;
    end else if ((byte_first & u8dec_pkg::LEAD2_MASK) == u8dec_pkg::LEAD2_TAG) begin
      s1_next.len = u8dec_pkg::LEN_2;
    end else if ((byte_first & u8dec_pkg::LEAD3_MASK) == u8dec_pkg::LEAD3_TAG) begin
      s1_next.len = u8dec_pkg::LEN_3;
    end else if ((byte_first & u8dec_pkg::LEAD4_MASK) == u8dec_pkg::LEAD4_TAG) begin
      s1_next.len = u8dec_pkg::LEN_4;
    end else begin
      s1_next.bad_lead = 1'b1;
    end
    s1_next.cont_ok[0] = ((byte_second & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_TAG);
    s1_next.cont_ok[1] = ((byte_third  & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_TAG);
    s1_next.cont_ok[2] = ((byte_fourth & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_TAG);
    s1_next.lead = byte_first[6:0];
    s1_next.tail = {byte_second[5:0], byte_third[5:0], byte_fourth[5:0]};
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    s1 <= s1_next;
  end

endmodule

`default_nettype wire

// File: sv/u8dec_resolve_stage.sv
// Second pipeline stage: status, consumed count and missing count.
`default_nettype none

module u8dec_resolve_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  u8dec_pkg::s1_t  s1,
  output u8dec_pkg::s2_t  s2
);

  u8dec_pkg::s2_t s2_next;
  logic           tail_ok;

  // Every byte after the lead and within the length must be a continuation.
  assign tail_ok = (s1.len < u8dec_pkg::LEN_2 || s1.cont_ok[0]) &&
                   (s1.len < u8dec_pkg::LEN_3 || s1.cont_ok[1]) &&
                   (s1.len < u8dec_pkg::LEN_4 || s1.cont_ok[2]);

  // An empty window wins over the lead, and a short window over the tail check.
  always_comb begin
    s2_next = '0;
    s2_next.valid = s1.valid && !rst;
    s2_next.lead  = s1.lead;
    s2_next.tail  = s1.tail;
    if (s1.empty) begin
      s2_next.status  = u8dec_pkg::ST_PREMATURE;
      s2_next.missing = 3'd1;
    end else if (s1.bad_lead) begin
      s2_next.status = u8dec_pkg::ST_INVALID;
    end else if (s1.len > s1.avail) begin
      s2_next.status  = u8dec_pkg::ST_PREMATURE;
      s2_next.missing = s1.len - s1.avail;
    end else if (!tail_ok) begin
      s2_next.status = u8dec_pkg::ST_INVALID;
    end else begin
      s2_next.status   = u8dec_pkg::ST_VALID;
      s2_next.consumed = s1.len;
    end
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    s2 <= s2_next;
  end

endmodule

`default_nettype wire

// File: sv/utf8_sequence_decoder_top.sv
// UTF-8 sequence decoder: lead stage, resolve stage and code point output register.
// done rises once the item has passed the lead, resolve and output registers.
// Throughput: one item per cycle; busy stays low, since the three register
// stages move every cycle and the receiver cannot stall.
// Reset: synchronous, active high; clears the stage valid bits, so no result
// appears until a new item is accepted.
`default_nettype none

module utf8_sequence_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  byte_first,
  input  wire logic [7:0]  byte_second,
  input  wire logic [7:0]  byte_third,
  input  wire logic [7:0]  byte_fourth,
  input  wire logic [2:0]  bytes_available,
  output logic             done,
  output logic [1:0]       status,
  output logic [2:0]       consumed,
  output logic [20:0]      code_point,
  output logic [2:0]       missing
);

  u8dec_pkg::s1_t s1;
  u8dec_pkg::s2_t s2;
  logic [20:0]    code_point_next;

  // The pipeline never stalls.
  assign busy = 1'b0;

  u8dec_lead_stage u_lead (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (start),
    .byte_first      (byte_first),
    .byte_second     (byte_second),
    .byte_third      (byte_third),
    .byte_fourth     (byte_fourth),
    .bytes_available (bytes_available),
    .s1              (s1)
  );

  u8dec_resolve_stage u_resolve (
    .clk (clk),
    .rst (rst),
    .s1  (s1),
    .s2  (s2)
  );

  // Assemble the code point; consumed is zero unless the status is valid.
  always_comb begin
    case (s2.consumed)
      u8dec_pkg::LEN_1: code_point_next = {14'd0, s2.lead};
      u8dec_pkg::LEN_2: code_point_next = {10'd0, s2.lead[4:0], s2.tail[17:12]};
      u8dec_pkg::LEN_3: code_point_next = {5'd0, s2.lead[3:0], s2.tail[17:6]};
      u8dec_pkg::LEN_4: code_point_next = {s2.lead[2:0], s2.tail};
      default:          code_point_next = 21'd0;
    endcase
  end

  // Output register; done is the only control bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2.valid;
    end
    status     <= s2.status;
    consumed   <= s2.consumed;
    missing    <= s2.missing;
    code_point <= code_point_next;
  end

endmodule

`default_nettype wire
